// File: hw/rtl/mpmm_pkg.sv
// ----------------------------------------------------------------------------
// mpmm_pkg
// Shared types, codes and defaults of the message-page mailbox matcher.
// ----------------------------------------------------------------------------
package mpmm_pkg;

	localparam int MAX_RANKS_DEF = 16;
	localparam int ENTRIES_DEF   = 10;
	localparam int PAGES_DEF     = 1024;

	localparam int RANK_W     = 4;
	localparam int TAG_W      = 16;
	localparam int ORD_W      = 12;
	localparam int PAGE_OUT_W = 10;
	localparam int ACT_W      = 5;
	localparam int ROW_BITS   = 32;

	localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

	localparam logic [1:0] OP_POST    = 2'd0;
	localparam logic [1:0] OP_TAKE    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_PAGE  = 2'd1;
	localparam logic [1:0] ST_NO_TABLE = 2'd2;
	localparam logic [1:0] ST_NO_MATCH = 2'd3;

	typedef struct packed {
		logic [1:0]        operation;
		logic [RANK_W-1:0] receiver;
		logic [RANK_W-1:0] sender;
		logic [TAG_W-1:0]  tag;
		logic [ORD_W-1:0]  order_index;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [PAGE_OUT_W-1:0] page_index;
	} result_t;

	typedef struct packed {
		logic init;
		logic alloc_rd;
		logic alloc_upd;
		logic alloc_fin;
		logic put_rd;
		logic put_wr;
		logic put_tbl;
	} fl_cmd_t;

	typedef struct packed {
		logic any_full;
		logic any_empty;
	} fl_sts_t;

	typedef struct packed {
		logic init;
		logic load;
		logic walk_step;
		logic new_link;
		logic ins;
		logic scan_rd;
		logic scan_next;
		logic next_tbl;
		logic take_hit;
		logic rel_clr;
		logic rel_tbl;
	} tbl_cmd_t;

	typedef struct packed {
		logic has_head;
		logic walk_more;
		logic t_full;
		logic free_ok;
		logic slot_ok;
		logic ent_valid;
		logic last_ent;
		logic has_next;
		logic step_last;
		logic hit;
	} tbl_sts_t;

endpackage

// File: hw/rtl/mpmm_freelist.sv
// ----------------------------------------------------------------------------
// mpmm_freelist
// Slot-ordered free page list: occupancy rows in a memory with per-row
// summaries, slot contents in a second memory.
// ----------------------------------------------------------------------------
module mpmm_freelist #(
	parameter int PAGES = mpmm_pkg::PAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mpmm_pkg::fl_cmd_t          cmd,
	input  logic [$clog2(PAGES)-1:0]   tbl_page,
	output mpmm_pkg::fl_sts_t          sts,
	output logic [$clog2(PAGES)-1:0]   page
);

	localparam int SW    = mpmm_pkg::ROW_BITS;
	localparam int ROWS  = (PAGES + SW - 1) / SW;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BW    = $clog2(SW);
	localparam int IDX_W = RW + BW;
	localparam int PG_W  = $clog2(PAGES);

	logic [2*SW-1:0] row_mem [ROWS];
	logic [PG_W-1:0] slot_mem [ROWS*SW];

	logic [ROWS-1:0] row_ok_q;
	logic [ROWS-1:0] any_full_q;
	logic [ROWS-1:0] any_empty_q;

	logic [RW-1:0]    row_q;
	logic             rowok_rd_q;
	logic [2*SW-1:0]  rowdat_q;
	logic [PG_W-1:0]  slot_q;
	logic [IDX_W-1:0] idx_q;
	logic             wbit_q;
	logic [PG_W-1:0]  page_q;
	logic [PG_W-1:0]  put_pg_q;

	logic [RW-1:0] ff_row, fe_row;
	logic          ff_any, fe_any;
	logic [SW-1:0] mask, cur_full, cur_wr, take_full, put_full, put_wr_v, empt;
	logic [BW-1:0] fb, eb;

	function automatic logic [SW-1:0] row_mask(input logic [RW-1:0] r);
		logic [SW-1:0] m;
		for (int b = 0; b < SW; b++) begin
			m[b] = (int'(r) * SW + b) < PAGES;
		end
		return m;
	endfunction

	always_comb begin
		ff_row = '0;
		ff_any = 1'b0;
		fe_row = '0;
		fe_any = 1'b0;
		for (int k = ROWS - 1; k >= 0; k--) begin
			if (any_full_q[k]) begin
				ff_row = RW'(k);
				ff_any = 1'b1;
			end
			if (any_empty_q[k]) begin
				fe_row = RW'(k);
				fe_any = 1'b1;
			end
		end
	end

	always_comb begin
		mask     = row_mask(row_q);
		cur_full = rowok_rd_q ? rowdat_q[SW-1:0] : mask;
		cur_wr   = rowok_rd_q ? rowdat_q[2*SW-1:SW] : '0;
		empt     = ~cur_full & mask;
		fb = '0;
		eb = '0;
		for (int b = SW - 1; b >= 0; b--) begin
			if (cur_full[b]) begin
				fb = BW'(b);
			end
			if (empt[b]) begin
				eb = BW'(b);
			end
		end
		take_full = cur_full & ~(SW'(1) << fb);
		put_full  = cur_full | (SW'(1) << eb);
		put_wr_v  = cur_wr | (SW'(1) << eb);
	end

	assign sts.any_full  = ff_any;
	assign sts.any_empty = fe_any;
	assign page          = page_q;

	always_ff @(posedge clk) begin
		if (cmd.alloc_rd) begin
			row_q      <= ff_row;
			rowdat_q   <= row_mem[ff_row];
			rowok_rd_q <= row_ok_q[ff_row];
		end else if (cmd.put_rd) begin
			row_q      <= fe_row;
			rowdat_q   <= row_mem[fe_row];
			rowok_rd_q <= row_ok_q[fe_row];
		end
		if (cmd.alloc_upd) begin
			row_mem[row_q] <= {cur_wr, take_full};
			slot_q         <= slot_mem[{row_q, fb}];
			idx_q          <= {row_q, fb};
			wbit_q         <= cur_wr[fb];
		end
		if (cmd.put_wr) begin
			row_mem[row_q]         <= {put_wr_v, put_full};
			slot_mem[{row_q, eb}]  <= put_pg_q;
		end
		if (cmd.alloc_fin) begin
			page_q <= wbit_q ? slot_q : idx_q[PG_W-1:0];
		end
		if (cmd.put_rd) begin
			put_pg_q <= cmd.put_tbl ? tbl_page : page_q;
			if (cmd.put_tbl) begin
				page_q <= tbl_page;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROWS; k++) begin
				row_ok_q[k]    <= 1'b0;
				any_full_q[k]  <= |row_mask(RW'(k));
				any_empty_q[k] <= 1'b0;
			end
		end else if (cmd.init) begin
			for (int k = 0; k < ROWS; k++) begin
				row_ok_q[k]    <= 1'b0;
				any_full_q[k]  <= |row_mask(RW'(k));
				any_empty_q[k] <= 1'b0;
			end
		end else if (cmd.alloc_upd) begin
			row_ok_q[row_q]    <= 1'b1;
			any_full_q[row_q]  <= |take_full;
			any_empty_q[row_q] <= |(~take_full & mask);
		end else if (cmd.put_wr) begin
			row_ok_q[row_q]    <= 1'b1;
			any_full_q[row_q]  <= |put_full;
			any_empty_q[row_q] <= |(~put_full & mask);
		end
	end

endmodule

// File: hw/rtl/mpmm_tables.sv
// ----------------------------------------------------------------------------
// mpmm_tables
// Page tables: entry memory, entry valid bits, counts, chain links and
// owners, with the current table and entry pointers of a request.
// ----------------------------------------------------------------------------
module mpmm_tables #(
	parameter int MAX_RANKS         = mpmm_pkg::MAX_RANKS_DEF,
	parameter int ENTRIES_PER_TABLE = mpmm_pkg::ENTRIES_DEF,
	parameter int PAGES             = mpmm_pkg::PAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mpmm_pkg::tbl_cmd_t               cmd,
	input  mpmm_pkg::req_t                   req,
	input  logic [mpmm_pkg::ACT_W-1:0]       active,
	input  logic [$clog2(PAGES)-1:0]         new_page,
	output mpmm_pkg::tbl_sts_t               sts,
	output logic [$clog2(PAGES)-1:0]         ent_page
);

	localparam int EPT  = ENTRIES_PER_TABLE;
	localparam int TW   = $clog2(MAX_RANKS);
	localparam int EW   = (EPT > 1) ? $clog2(EPT) : 1;
	localparam int CW   = $clog2(EPT + 1);
	localparam int SCW  = $clog2(MAX_RANKS + 1);
	localparam int NE   = MAX_RANKS * EPT;
	localparam int AW   = $clog2(NE);
	localparam int PG_W = $clog2(PAGES);
	localparam int RK_W = mpmm_pkg::RANK_W;

	typedef struct packed {
		logic [RK_W-1:0]            sender;
		logic [RK_W-1:0]            receiver;
		logic [mpmm_pkg::TAG_W-1:0] tag;
		logic [mpmm_pkg::ORD_W-1:0] order_index;
		logic [PG_W-1:0]            page;
	} ent_t;

	ent_t ent_mem [NE];
	ent_t rd_q;

	logic [NE-1:0]        ent_ok_q;
	logic [CW-1:0]        cnt_q     [MAX_RANKS];
	logic [MAX_RANKS-1:0] nxt_ok_q;
	logic [TW-1:0]        nxt_q     [MAX_RANKS];
	logic [MAX_RANKS-1:0] prv_ok_q;
	logic [TW-1:0]        prv_q     [MAX_RANKS];
	logic [MAX_RANKS-1:0] own_ok_q;
	logic [RK_W-1:0]      own_q     [MAX_RANKS];

	logic [TW-1:0]  t_q;
	logic [SCW-1:0] step_q;
	logic [EW-1:0]  i_q;

	logic [RK_W-1:0]            rq_r_q, rq_s_q;
	logic [mpmm_pkg::TAG_W-1:0] rq_tag_q;
	logic [mpmm_pkg::ORD_W-1:0] rq_ord_q;

	logic [TW-1:0] rt, ftbl, p;
	logic          free_ok, slot_ok, t_full, unlink;
	logic [EW-1:0] slot_k;
	logic [AW-1:0] cur_addr, ins_addr;
	logic [CW-1:0] dec;

	always_comb begin
		rt       = TW'(rq_r_q);
		cur_addr = AW'(int'(t_q) * EPT + int'(i_q));
		t_full   = cnt_q[t_q] >= CW'(EPT);
		ftbl     = '0;
		free_ok  = 1'b0;
		for (int k = 0; k < MAX_RANKS; k++) begin
			if (!own_ok_q[k]) begin
				ftbl    = TW'(k);
				free_ok = 1'b1;
			end
		end
		slot_k  = '0;
		slot_ok = 1'b0;
		for (int k = EPT - 1; k >= 0; k--) begin
			if (!ent_ok_q[AW'(int'(t_q) * EPT + k)]) begin
				slot_k  = EW'(k);
				slot_ok = 1'b1;
			end
		end
		ins_addr = AW'(int'(t_q) * EPT + int'(slot_k));
		dec      = (cnt_q[t_q] != '0) ? cnt_q[t_q] - CW'(1) : cnt_q[t_q];
		unlink   = (dec == '0) && prv_ok_q[t_q];
		p        = prv_q[t_q];
	end

	assign sts.has_head  = (int'(rq_r_q) < MAX_RANKS) && own_ok_q[rt] && (own_q[rt] == rq_r_q);
	assign sts.walk_more = (step_q != SCW'(MAX_RANKS)) && nxt_ok_q[t_q] && t_full;
	assign sts.t_full    = t_full;
	assign sts.free_ok   = free_ok;
	assign sts.slot_ok   = slot_ok;
	assign sts.ent_valid = ent_ok_q[cur_addr];
	assign sts.last_ent  = i_q == EW'(EPT - 1);
	assign sts.has_next  = nxt_ok_q[t_q];
	assign sts.step_last = step_q == SCW'(MAX_RANKS - 1);
	assign sts.hit       = (rd_q.sender == rq_s_q) && (rd_q.receiver == rq_r_q)
	                       && (rd_q.tag == rq_tag_q) && (rd_q.order_index == rq_ord_q);
	assign ent_page      = rd_q.page;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rq_r_q   <= req.receiver;
			rq_s_q   <= req.sender;
			rq_tag_q <= req.tag;
			rq_ord_q <= req.order_index;
		end
		if (cmd.scan_rd) begin
			rd_q <= ent_mem[cur_addr];
		end
		if (cmd.ins) begin
			ent_mem[ins_addr] <= '{sender: rq_s_q, receiver: rq_r_q, tag: rq_tag_q,
			                       order_index: rq_ord_q, page: new_page};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_ok_q <= '0;
			for (int k = 0; k < MAX_RANKS; k++) begin
				cnt_q[k]    <= '0;
				nxt_ok_q[k] <= 1'b0;
				nxt_q[k]    <= '0;
				prv_ok_q[k] <= 1'b0;
				prv_q[k]    <= '0;
				own_ok_q[k] <= k < int'(mpmm_pkg::ACT_RESET);
				own_q[k]    <= RK_W'(k);
			end
			t_q    <= '0;
			step_q <= '0;
			i_q    <= '0;
		end else if (cmd.init) begin
			ent_ok_q <= '0;
			for (int k = 0; k < MAX_RANKS; k++) begin
				cnt_q[k]    <= '0;
				nxt_ok_q[k] <= 1'b0;
				nxt_q[k]    <= '0;
				prv_ok_q[k] <= 1'b0;
				prv_q[k]    <= '0;
				own_ok_q[k] <= k < int'(active);
				own_q[k]    <= RK_W'(k);
			end
		end else begin
			if (cmd.load) begin
				t_q    <= TW'(req.receiver);
				step_q <= '0;
				i_q    <= '0;
			end
			if (cmd.walk_step) begin
				t_q    <= nxt_q[t_q];
				step_q <= step_q + SCW'(1);
			end
			if (cmd.new_link) begin
				own_ok_q[ftbl] <= 1'b1;
				own_q[ftbl]    <= rq_r_q;
				nxt_ok_q[t_q]  <= 1'b1;
				nxt_q[t_q]     <= ftbl;
				cnt_q[ftbl]    <= '0;
				nxt_ok_q[ftbl] <= 1'b0;
				nxt_q[ftbl]    <= '0;
				prv_ok_q[ftbl] <= 1'b1;
				prv_q[ftbl]    <= t_q;
				t_q            <= ftbl;
			end
			if (cmd.ins) begin
				ent_ok_q[ins_addr] <= 1'b1;
				cnt_q[t_q]         <= cnt_q[t_q] + CW'(1);
			end
			if (cmd.scan_next) begin
				i_q <= i_q + EW'(1);
			end
			if (cmd.next_tbl) begin
				t_q    <= nxt_q[t_q];
				step_q <= step_q + SCW'(1);
				i_q    <= '0;
			end
			if (cmd.rel_clr) begin
				ent_ok_q[cur_addr] <= 1'b0;
			end
			if (cmd.take_hit) begin
				ent_ok_q[cur_addr] <= 1'b0;
				cnt_q[t_q]         <= dec;
				if (unlink) begin
					nxt_ok_q[p] <= nxt_ok_q[t_q];
					nxt_q[p]    <= nxt_q[t_q];
					if (nxt_ok_q[t_q]) begin
						prv_q[nxt_q[t_q]] <= p;
					end
					cnt_q[t_q]    <= '0;
					nxt_ok_q[t_q] <= 1'b0;
					nxt_q[t_q]    <= '0;
					prv_ok_q[t_q] <= 1'b0;
					prv_q[t_q]    <= '0;
					own_ok_q[t_q] <= 1'b0;
				end
			end
			if (cmd.rel_tbl) begin
				cnt_q[t_q]    <= '0;
				nxt_ok_q[t_q] <= 1'b0;
				nxt_q[t_q]    <= '0;
				prv_ok_q[t_q] <= 1'b0;
				prv_q[t_q]    <= '0;
				own_ok_q[t_q] <= 1'b0;
				t_q           <= nxt_q[t_q];
				step_q        <= step_q + SCW'(1);
				i_q           <= '0;
			end
		end
	end

endmodule

// File: hw/rtl/mpmm_ctrl.sv
// ----------------------------------------------------------------------------
// mpmm_ctrl
// Request sequencer: steps the free list and the tables through post, take
// and release, and presents the result word.
// ----------------------------------------------------------------------------
module mpmm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          op,
	output logic                busy,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  mpmm_pkg::fl_sts_t   fl_sts,
	input  mpmm_pkg::tbl_sts_t  tbl_sts,
	output mpmm_pkg::fl_cmd_t   fl_cmd,
	output mpmm_pkg::tbl_cmd_t  tbl_cmd,
	output logic                done,
	output logic [1:0]          status,
	output logic                page_en
);

	typedef enum logic [14:0] {
		S_IDLE   = 15'h0001,
		S_A_RD   = 15'h0002,
		S_A_UPD  = 15'h0004,
		S_A_FIN  = 15'h0008,
		S_HEAD   = 15'h0010,
		S_P_WALK = 15'h0020,
		S_P_INS  = 15'h0040,
		S_T_CHK  = 15'h0080,
		S_T_CMP  = 15'h0100,
		S_T_ADV  = 15'h0200,
		S_R_CHK  = 15'h0400,
		S_R_ADV  = 15'h0800,
		S_PB_RD  = 15'h1000,
		S_PB_WR  = 15'h2000,
		S_DONE   = 15'h4000
	} state_t;

	state_t     state_q, state_n;
	logic [1:0] op_q, status_q, status_n;
	logic       is_rel;

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign done      = state_q == S_DONE;
	assign status    = status_q;
	assign page_en   = (status_q == mpmm_pkg::ST_OK)
	                   && ((op_q == mpmm_pkg::OP_POST) || (op_q == mpmm_pkg::OP_TAKE));
	assign is_rel    = op_q == mpmm_pkg::OP_RELEASE;

	always_comb begin
		state_n  = state_q;
		status_n = status_q;
		fl_cmd   = '0;
		tbl_cmd  = '0;
		fl_cmd.init  = cfg_valid && cfg_ready;
		tbl_cmd.init = cfg_valid && cfg_ready;
		fl_cmd.put_tbl = op_q != mpmm_pkg::OP_POST;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					tbl_cmd.load = 1'b1;
					status_n     = mpmm_pkg::ST_OK;
					if (op == mpmm_pkg::OP_POST) begin
						state_n = S_A_RD;
					end else if (op == mpmm_pkg::OP_TAKE || op == mpmm_pkg::OP_RELEASE) begin
						state_n = S_HEAD;
					end else begin
						state_n = S_DONE;
					end
				end
			end
			S_A_RD: begin
				if (!fl_sts.any_full) begin
					status_n = mpmm_pkg::ST_NO_PAGE;
					state_n  = S_DONE;
				end else begin
					fl_cmd.alloc_rd = 1'b1;
					state_n         = S_A_UPD;
				end
			end
			S_A_UPD: begin
				fl_cmd.alloc_upd = 1'b1;
				state_n          = S_A_FIN;
			end
			S_A_FIN: begin
				fl_cmd.alloc_fin = 1'b1;
				state_n          = S_HEAD;
			end
			S_HEAD: begin
				if (!tbl_sts.has_head) begin
					if (op_q == mpmm_pkg::OP_POST) begin
						status_n = mpmm_pkg::ST_NO_TABLE;
						state_n  = S_PB_RD;
					end else if (op_q == mpmm_pkg::OP_TAKE) begin
						status_n = mpmm_pkg::ST_NO_MATCH;
						state_n  = S_DONE;
					end else begin
						status_n = mpmm_pkg::ST_NO_TABLE;
						state_n  = S_DONE;
					end
				end else if (op_q == mpmm_pkg::OP_POST) begin
					state_n = S_P_WALK;
				end else if (op_q == mpmm_pkg::OP_TAKE) begin
					state_n = S_T_CHK;
				end else begin
					state_n = S_R_CHK;
				end
			end
			S_P_WALK: begin
				if (tbl_sts.walk_more) begin
					tbl_cmd.walk_step = 1'b1;
				end else if (tbl_sts.t_full) begin
					if (tbl_sts.free_ok) begin
						tbl_cmd.new_link = 1'b1;
						state_n          = S_P_INS;
					end else begin
						status_n = mpmm_pkg::ST_NO_TABLE;
						state_n  = S_PB_RD;
					end
				end else begin
					state_n = S_P_INS;
				end
			end
			S_P_INS: begin
				if (tbl_sts.slot_ok) begin
					tbl_cmd.ins = 1'b1;
					state_n     = S_DONE;
				end else begin
					status_n = mpmm_pkg::ST_NO_TABLE;
					state_n  = S_PB_RD;
				end
			end
			S_T_CHK: begin
				if (tbl_sts.ent_valid) begin
					tbl_cmd.scan_rd = 1'b1;
					state_n         = S_T_CMP;
				end else begin
					state_n = S_T_ADV;
				end
			end
			S_T_CMP: begin
				if (tbl_sts.hit) begin
					tbl_cmd.take_hit = 1'b1;
					state_n          = S_PB_RD;
				end else begin
					state_n = S_T_ADV;
				end
			end
			S_T_ADV: begin
				if (!tbl_sts.last_ent) begin
					tbl_cmd.scan_next = 1'b1;
					state_n           = S_T_CHK;
				end else if (tbl_sts.has_next && !tbl_sts.step_last) begin
					tbl_cmd.next_tbl = 1'b1;
					state_n          = S_T_CHK;
				end else begin
					status_n = mpmm_pkg::ST_NO_MATCH;
					state_n  = S_DONE;
				end
			end
			S_R_CHK: begin
				if (tbl_sts.ent_valid) begin
					tbl_cmd.scan_rd = 1'b1;
					tbl_cmd.rel_clr = 1'b1;
					state_n         = S_PB_RD;
				end else begin
					state_n = S_R_ADV;
				end
			end
			S_R_ADV: begin
				if (!tbl_sts.last_ent) begin
					tbl_cmd.scan_next = 1'b1;
					state_n           = S_R_CHK;
				end else begin
					tbl_cmd.rel_tbl = 1'b1;
					if (tbl_sts.has_next && !tbl_sts.step_last) begin
						state_n = S_R_CHK;
					end else begin
						state_n = S_DONE;
					end
				end
			end
			S_PB_RD: begin
				if (fl_sts.any_empty) begin
					fl_cmd.put_rd = 1'b1;
					state_n       = S_PB_WR;
				end else begin
					state_n = is_rel ? S_R_ADV : S_DONE;
				end
			end
			S_PB_WR: begin
				fl_cmd.put_wr = 1'b1;
				state_n       = is_rel ? S_R_ADV : S_DONE;
			end
			S_DONE: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= mpmm_pkg::OP_POST;
			status_q <= mpmm_pkg::ST_OK;
		end else begin
			state_q  <= state_n;
			status_q <= status_n;
			if (state_q == S_IDLE && start) begin
				op_q <= op;
			end
		end
	end

endmodule

// File: hw/rtl/message_page_mailbox_matcher.sv
// ----------------------------------------------------------------------------
// message_page_mailbox_matcher
// Message-page mailbox with tag matching: post, take and release of pages
// over per-receiver chains of page tables.
//
//   port group            direction  handshake
//   start/busy/req        in         start & !busy
//   done/result           out        done, one cycle, no back pressure
//   cfg_valid/ready/data  in         cfg_valid & cfg_ready, idle and no start
//
// one request at a time; busy stays high until the cycle after done
// post allocates a page, walks the full tables of the chain, links a free
// table when all are full and inserts the entry; the page goes back to the
// free list when no table or entry is free
// take scans the entries of the chain and on a hit clears the entry and
// returns its page; release clears every valid entry, returns its page and
// frees each table of the chain; reset and a configuration word need no
// clearing pass
module message_page_mailbox_matcher #(
	parameter int MAX_RANKS         = mpmm_pkg::MAX_RANKS_DEF,
	parameter int ENTRIES_PER_TABLE = mpmm_pkg::ENTRIES_DEF,
	parameter int PAGES             = mpmm_pkg::PAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  mpmm_pkg::req_t               req,
	output logic                         done,
	output mpmm_pkg::result_t            result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mpmm_pkg::ACT_W-1:0]   cfg_data
);

	localparam int PG_W = $clog2(PAGES);

	mpmm_pkg::fl_cmd_t  fl_cmd;
	mpmm_pkg::fl_sts_t  fl_sts;
	mpmm_pkg::tbl_cmd_t tbl_cmd;
	mpmm_pkg::tbl_sts_t tbl_sts;

	logic [PG_W-1:0] page, ent_page;
	logic [1:0]      status;
	logic            page_en;

	mpmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (req.operation),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.fl_sts    (fl_sts),
		.tbl_sts   (tbl_sts),
		.fl_cmd    (fl_cmd),
		.tbl_cmd   (tbl_cmd),
		.done      (done),
		.status    (status),
		.page_en   (page_en)
	);

	mpmm_freelist #(
		.PAGES (PAGES)
	) u_freelist (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (fl_cmd),
		.tbl_page (ent_page),
		.sts      (fl_sts),
		.page     (page)
	);

	mpmm_tables #(
		.MAX_RANKS         (MAX_RANKS),
		.ENTRIES_PER_TABLE (ENTRIES_PER_TABLE),
		.PAGES             (PAGES)
	) u_tables (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (tbl_cmd),
		.req        (req),
		.active     (cfg_data),
		.new_page   (page),
		.sts        (tbl_sts),
		.ent_page   (ent_page)
	);

	assign result.status     = status;
	assign result.page_index = page_en ? mpmm_pkg::PAGE_OUT_W'(page) : '0;

endmodule
